// File: hdl/nisf_pkg.sv
// shared types, constants and helpers for the normalized iir section filter
`default_nettype none

package nisf_pkg;

   // sample width is fixed by the payload structs
   localparam int SAMPLE_W = 16;

   // defaults for the top-level parameters
   localparam int COEF_BITS_DEF      = 24;
   localparam int COEF_FRAC_BITS_DEF = 16;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEN_LEAD   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEN_FIRST  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEN_SECOND = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NUM_NOW    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NUM_FIRST  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NUM_SECOND = 3'd5;

   // request opcodes
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // product terms, issued to the shared multiplier in this order
   localparam int TERM_BITS = 3;
   localparam logic [TERM_BITS-1:0] TERM_NUM_NOW    = 3'd0;
   localparam logic [TERM_BITS-1:0] TERM_NUM_FIRST  = 3'd1;
   localparam logic [TERM_BITS-1:0] TERM_NUM_SECOND = 3'd2;
   localparam logic [TERM_BITS-1:0] TERM_DEN_FIRST  = 3'd3;
   localparam logic [TERM_BITS-1:0] TERM_DEN_SECOND = 3'd4;
   localparam logic [TERM_BITS-1:0] TERM_LAST       = TERM_DEN_SECOND;

   typedef struct packed {
      logic                       opcode;
      logic signed [SAMPLE_W-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       saturated;
      logic                       div_error;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                 load;      // capture sample, clear accumulator
      logic                 mul_en;    // multiply the selected term
      logic [TERM_BITS-1:0] term;
      logic                 acc_en;    // fold the registered product in
      logic                 div_init;  // load divider with magnitudes
      logic                 div_step;  // two quotient bits
      logic                 commit;    // write result and advance history
      logic                 flush;     // clear history
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_zero;
   } dp_status_type;

   // accumulator width: exact sum of five products, capped at 64 bits (wraps there)
   function automatic int acc_bits_f(input int coef_bits);
      int w;
      w = coef_bits + SAMPLE_W + 3;
      if (w > 64) begin
         w = 64;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// File: hdl/normalized_iir_section_filter.sv
// top level of the second-order normalized direct form i iir filter
`default_nettype none

// Second-order direct form I IIR section, y = (b1*x + b2*x1 + b3*x2 - a2*y1 - a3*y2) / a1,
// quotient truncated toward zero and clipped to 16 bits (saturated flag), div_error and a
// zero output when a1 is zero. Coefficients are signed Q8.16 registers written through the
// csr port; the user must write them only while the block is idle, which the block itself
// does not enforce. History is two inputs and two outputs. A filter beat is taken only
// while the block is idle; its five products then go through one shared multiplier, then
// come an accumulate step, a divider load, a divide at two quotient bits per cycle and a
// commit; the divide is skipped when a1 is zero. The result sits in an output register, so
// the next beat is taken while it waits; commit waits only when that register is still
// full. A flush beat clears the history and gives no result.

module normalized_iir_section_filter import nisf_pkg::*; #(
   parameter int COEF_BITS      = COEF_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_data,
   // response channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   // coefficient writes
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COEF_BITS-1:0]      csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: owns the handshakes and steps the datapath
   nisf_ctrl #(
      .COEF_BITS (COEF_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   // arithmetic, coefficient registers, history and result register
   nisf_dp #(
      .COEF_BITS      (COEF_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sample_in (req_data.sample_in),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // a result is written only into a free output slot
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("commit into occupied output register");

   // one datapath operation at a time, apart from accumulate overlapping multiply
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul_en, cmd.div_init, cmd.div_step, cmd.commit, cmd.flush}))
      else $error("overlapping datapath commands");

   // a filter beat keeps the block busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.opcode == OP_FILTER) |=> req_stall)
      else $error("filter beat did not occupy the block");

   // a commit always presents a response beat
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without response beat");

endmodule

`default_nettype wire

// File: hdl/nisf_ctrl.sv
// sequencer for the filter: multiply-accumulate, divide, commit
`default_nettype none

module nisf_ctrl import nisf_pkg::*; #(
   parameter int COEF_BITS = COEF_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_opcode,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   localparam int ACC_BITS  = acc_bits_f(COEF_BITS);
   localparam int DIV_STEPS = (ACC_BITS + 1) / 2;
   localparam int CNT_BITS  = (DIV_STEPS > 8) ? $clog2(DIV_STEPS) : 3;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_MACC = 3'd2;
   localparam logic [2:0] S_DIVI = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_FLUSH) begin
                  cmd.flush = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  cnt_in   = '0;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.term   = cnt_ff[TERM_BITS-1:0];
            cmd.acc_en = (cnt_ff != '0);
            if (cnt_ff == CNT_BITS'(TERM_LAST)) begin
               state_in = S_MACC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MACC: begin
            cmd.acc_en = 1'b1;
            state_in   = status.div_zero ? S_DONE : S_DIVI;
         end
         S_DIVI: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hdl/nisf_dp.sv
// filter datapath: coefficients, history, shared multiplier, accumulator, divider
`default_nettype none

module nisf_dp import nisf_pkg::*; #(
   parameter int COEF_BITS      = COEF_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [COEF_BITS-1:0]       csr_wdata,
   input  wire logic signed [SAMPLE_W-1:0] sample_in,
   input  wire dp_cmd_type                 cmd,
   output dp_status_type                   status,
   output rsp_type                         rsp_data
);

   localparam int ACC_BITS  = acc_bits_f(COEF_BITS);
   localparam int DIV_BITS  = 2 * ((ACC_BITS + 1) / 2);
   localparam int PROD_BITS = COEF_BITS + SAMPLE_W;
   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'd1 << COEF_FRAC_BITS);
   localparam logic [DIV_BITS-1:0]  LIM_POS  = DIV_BITS'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
   localparam logic [DIV_BITS-1:0]  LIM_NEG  = LIM_POS + 1'b1;

   // coefficients
   logic signed [COEF_BITS-1:0] den_lead_ff, den_first_ff, den_second_ff;
   logic signed [COEF_BITS-1:0] num_now_ff, num_first_ff, num_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         den_lead_ff   <= COEF_ONE;
         den_first_ff  <= '0;
         den_second_ff <= '0;
         num_now_ff    <= COEF_ONE;
         num_first_ff  <= '0;
         num_second_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEN_LEAD:   den_lead_ff   <= csr_wdata;
            REG_DEN_FIRST:  den_first_ff  <= csr_wdata;
            REG_DEN_SECOND: den_second_ff <= csr_wdata;
            REG_NUM_NOW:    num_now_ff    <= csr_wdata;
            REG_NUM_FIRST:  num_first_ff  <= csr_wdata;
            REG_NUM_SECOND: num_second_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign status.div_zero = (den_lead_ff == '0);

   // current sample and history
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] xh0_ff, xh1_ff, yh0_ff, yh1_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= sample_in;
      end
   end

   // shared multiplier, one term a cycle
   logic signed [COEF_BITS-1:0] coef_sel;
   logic signed [SAMPLE_W-1:0]  opnd_sel;
   logic signed [PROD_BITS-1:0] prod_in, prod_ff;
   logic                        prod_sub_ff;

   always_comb begin
      case (cmd.term)
         TERM_NUM_NOW: begin
            coef_sel = num_now_ff;
            opnd_sel = x_ff;
         end
         TERM_NUM_FIRST: begin
            coef_sel = num_first_ff;
            opnd_sel = xh0_ff;
         end
         TERM_NUM_SECOND: begin
            coef_sel = num_second_ff;
            opnd_sel = xh1_ff;
         end
         TERM_DEN_FIRST: begin
            coef_sel = den_first_ff;
            opnd_sel = yh0_ff;
         end
         TERM_DEN_SECOND: begin
            coef_sel = den_second_ff;
            opnd_sel = yh1_ff;
         end
         default: begin
            coef_sel = '0;
            opnd_sel = '0;
         end
      endcase
   end

   assign prod_in = coef_sel * opnd_sel;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff     <= prod_in;
         prod_sub_ff <= (cmd.term inside {TERM_DEN_FIRST, TERM_DEN_SECOND});
      end
   end

   // accumulator
   logic signed [ACC_BITS-1:0] acc_ff, prod_ext;

   assign prod_ext = ACC_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= prod_sub_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
      end
   end

   // restoring divider on magnitudes, two quotient bits a cycle
   logic [ACC_BITS-1:0]  acc_mag;
   logic [COEF_BITS-1:0] lead_mag;
   logic [COEF_BITS-1:0] rem_ff, rem_in, dsr_ff;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic                 neg_ff;
   logic [COEF_BITS:0]   trial;
   logic                 ge;

   assign acc_mag  = acc_ff[ACC_BITS-1] ? ACC_BITS'(-acc_ff) : ACC_BITS'(acc_ff);
   assign lead_mag = den_lead_ff[COEF_BITS-1] ? COEF_BITS'(-den_lead_ff)
                                              : COEF_BITS'(den_lead_ff);

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      ge     = 1'b0;
      for (int i = 0; i < 2; i++) begin
         trial = {rem_in, quo_in[DIV_BITS-1]};
         ge    = (trial >= {1'b0, dsr_ff});
         if (ge) begin
            rem_in = COEF_BITS'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[COEF_BITS-1:0];
         end
         quo_in = {quo_in[DIV_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= DIV_BITS'(acc_mag);
         dsr_ff <= lead_mag;
         neg_ff <= acc_ff[ACC_BITS-1] ^ den_lead_ff[COEF_BITS-1];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // sign, clipping and zero-divisor handling
   logic                neg, sat;
   logic [DIV_BITS-1:0] lim;
   logic [SAMPLE_W-1:0] mag;
   rsp_type             res;

   assign neg = neg_ff && (quo_ff != '0);
   assign lim = neg ? LIM_NEG : LIM_POS;
   assign sat = (quo_ff > lim);
   assign mag = sat ? lim[SAMPLE_W-1:0] : quo_ff[SAMPLE_W-1:0];

   always_comb begin
      if (status.div_zero) begin
         res.sample_out = '0;
         res.saturated  = 1'b0;
         res.div_error  = 1'b1;
      end else begin
         res.sample_out = neg ? -mag : mag;
         res.saturated  = sat;
         res.div_error  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.flush) begin
         xh0_ff <= '0;
         xh1_ff <= '0;
         yh0_ff <= '0;
         yh1_ff <= '0;
      end else if (cmd.commit) begin
         xh1_ff <= xh0_ff;
         xh0_ff <= x_ff;
         yh1_ff <= yh0_ff;
         yh0_ff <= res.sample_out;
      end
   end

endmodule

`default_nettype wire

// File: bench/tb_normalized_iir_section_filter.sv
// self-checking testbench for the normalized second-order iir section filter
`timescale 1ns / 1ps

module tb_normalized_iir_section_filter;
   import nisf_pkg::*;

   // register indexes past the end of the list, writes there must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
   localparam int REG_COUNT = 6;

   // settle time, with margin over the longest accept-to-accept time
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 85;

   localparam logic signed [COEF_BITS_DEF-1:0] COEF_MAX = 24'sh7fffff;
   localparam logic signed [COEF_BITS_DEF-1:0] COEF_MIN = -24'sh800000;
   localparam logic signed [COEF_BITS_DEF-1:0] COEF_ONE = 24'sh010000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [COEF_BITS_DEF-1:0]  csr_wdata;

   // coefficient copy and filter history, kept in step with the block
   logic signed [COEF_BITS_DEF-1:0] coef [REG_COUNT];
   logic signed [SAMPLE_W-1:0]      x_hist1, x_hist2, y_hist1, y_hist2;

   // filtered samples still owed by the block, oldest first
   rsp_type outputs_due [$];

   int errors = 0;

   // idling controls for the sender and the receiver
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   int hold_request = 0;

   always #5 clock = ~clock;

   normalized_iir_section_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // one filter step: sum of five products, divide by the lead coefficient
   // truncating toward zero, clip to the sample range, then shift history
   function automatic rsp_type filter_step(input logic signed [SAMPLE_W-1:0] x);
      longint  acc;
      longint  lead;
      longint  num_mag;
      longint  den_mag;
      longint  quo;
      longint  lim;
      logic    neg;
      rsp_type r;
      acc = longint'(coef[REG_NUM_NOW]) * longint'(x);
      acc += longint'(coef[REG_NUM_FIRST]) * longint'(x_hist1);
      acc += longint'(coef[REG_NUM_SECOND]) * longint'(x_hist2);
      acc -= longint'(coef[REG_DEN_FIRST]) * longint'(y_hist1);
      acc -= longint'(coef[REG_DEN_SECOND]) * longint'(y_hist2);
      lead = longint'(coef[REG_DEN_LEAD]);
      r = '0;
      if (lead == 0) begin
         // no quotient, zero goes out and into the history
         r.div_error = 1'b1;
      end else begin
         num_mag = (acc < 0) ? -acc : acc;
         den_mag = (lead < 0) ? -lead : lead;
         quo = num_mag / den_mag;
         neg = ((acc < 0) != (lead < 0)) && (quo != 0);
         lim = neg ? 32768 : 32767;
         if (quo > lim) begin
            quo = lim;
            r.saturated = 1'b1;
         end
         r.sample_out = 16'(neg ? -quo : quo);
      end
      x_hist2 = x_hist1;
      x_hist1 = x;
      y_hist2 = y_hist1;
      y_hist1 = r.sample_out;
      return r;
   endfunction

   // one coefficient write, mirrored into the local copy when it lands
   task automatic write_coef(input logic [CSR_INDEX_BITS-1:0] idx,
                             input logic signed [COEF_BITS_DEF-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      if (idx < REG_COUNT) begin
         coef[idx] = val;
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // offer one beat, hold it until taken, then optionally go quiet
   task automatic send_beat(input logic op, input logic signed [SAMPLE_W-1:0] smp);
      int gap;
      @(negedge clock);
      req_valid         = 1'b1;
      req_data.opcode    = op;
      req_data.sample_in = smp;
      do begin
         @(posedge clock);
      end while (req_stall);
      // beat taken at this edge
      if (op == OP_FLUSH) begin
         x_hist1 = '0;
         x_hist2 = '0;
         y_hist1 = '0;
         y_hist2 = '0;
      end else begin
         outputs_due.push_back(filter_step(smp));
      end
      gap = 0;
      if (tx_idle_on && $urandom_range(0, 1) == 0) begin
         gap = idle_len();
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_data  = req_type'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // drop valid, let every owed sample come out, then let the block settle
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (outputs_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 16'sh7fff;
         1: return -16'sh8000;
         2: return 16'sh0000;
         3: return -16'sh0001;
         4, 5, 6: return 16'($signed($urandom_range(0, 2000)) - 1000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_BITS_DEF-1:0] rand_coef();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         3, 4, 5: return 24'($signed($urandom_range(0, 262144)) - 131072);
         default: return 24'($urandom);
      endcase
   endfunction

   // the lead coefficient mostly sits near one so the output stays in range
   function automatic logic signed [COEF_BITS_DEF-1:0] rand_lead();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return '0;
         1: return COEF_MAX;
         2: return COEF_MIN;
         3: return 24'($urandom);
         default: return 24'($signed($urandom_range(16384, 262144))
                              * ($urandom_range(0, 1) ? 1 : -1));
      endcase
   endfunction

   // identity filter after reset, sample extremes and a flush
   task automatic test_reset_defaults();
      send_beat(OP_FILTER, 16'sh7fff);
      send_beat(OP_FILTER, -16'sh8000);
      send_beat(OP_FILTER, 16'sh0000);
      send_beat(OP_FILTER, -16'sh0001);
      send_beat(OP_FLUSH, 16'sh7fff);
      send_beat(OP_FILTER, 16'sh0001);
      send_beat(OP_FILTER, 16'sh0064);
      wait_until_idle();
   endtask

   // tiny and extreme lead coefficients drive the quotient past both rails
   task automatic test_saturation();
      write_coef(REG_DEN_LEAD, 24'sh000001);
      send_beat(OP_FILTER, 16'sh7fff);
      send_beat(OP_FILTER, -16'sh8000);
      send_beat(OP_FILTER, 16'sh0000);
      wait_until_idle();
      write_coef(REG_DEN_LEAD, COEF_MIN);
      write_coef(REG_DEN_FIRST, COEF_MAX);
      write_coef(REG_DEN_SECOND, COEF_MAX);
      write_coef(REG_NUM_NOW, COEF_MAX);
      write_coef(REG_NUM_FIRST, COEF_MIN);
      write_coef(REG_NUM_SECOND, COEF_MAX);
      send_beat(OP_FILTER, 16'sh7fff);
      send_beat(OP_FILTER, -16'sh8000);
      send_beat(OP_FILTER, 16'sh7fff);
      wait_until_idle();
   endtask

   // zero lead coefficient flags an error and stores zero as the new output
   task automatic test_zero_lead();
      write_coef(REG_DEN_LEAD, '0);
      write_coef(REG_DEN_FIRST, COEF_ONE);
      write_coef(REG_DEN_SECOND, '0);
      write_coef(REG_NUM_NOW, COEF_ONE);
      write_coef(REG_NUM_FIRST, COEF_ONE);
      write_coef(REG_NUM_SECOND, '0);
      send_beat(OP_FILTER, 16'sh03e8);
      send_beat(OP_FILTER, -16'sh0005);
      wait_until_idle();
      // out-of-range indexes must leave the coefficients alone
      write_coef(REG_SPARE_LO, COEF_MAX);
      write_coef(REG_SPARE_HI, COEF_MIN);
      write_coef(REG_DEN_LEAD, COEF_ONE);
      send_beat(OP_FILTER, 16'sh0007);
      send_beat(OP_FILTER, 16'sh0003);
      send_beat(OP_FLUSH, -16'sh0001);
      send_beat(OP_FILTER, 16'sh0002);
      wait_until_idle();
   endtask

   // receiver holds off for a long time while beats keep coming
   task automatic test_backpressure();
      tx_idle_on   = 1'b0;
      rx_idle_on   = 1'b0;
      hold_request = 400;
      repeat (12) send_beat(OP_FILTER, rand_sample());
      wait_until_idle();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // all-max, all-min, then random coefficient sets, random samples with the odd flush mixed in
   task automatic test_random_traffic();
      int idx;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         tx_idle_on = (phase % 3) != 0;
         rx_idle_on = (phase % 4) != 1;
         for (idx = 0; idx < REG_COUNT; idx++) begin
            if (phase == 0) begin
               write_coef(idx[CSR_INDEX_BITS-1:0], COEF_MAX);
            end else if (phase == 1) begin
               write_coef(idx[CSR_INDEX_BITS-1:0], COEF_MIN);
            end else if (idx == REG_DEN_LEAD) begin
               write_coef(idx[CSR_INDEX_BITS-1:0], rand_lead());
            end else begin
               write_coef(idx[CSR_INDEX_BITS-1:0], rand_coef());
            end
         end
         if ($urandom_range(0, 1)) begin
            write_coef($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, rand_coef());
         end
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(0, 24) == 0) begin
               send_beat(OP_FLUSH, 16'($urandom));
            end else begin
               send_beat(OP_FILTER, rand_sample());
            end
         end
         wait_until_idle();
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // receiver stall pattern, one drive per falling edge
   initial begin : drive_rsp_stall
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall = 1'b1;
         end else if (hold_request > 0) begin
            // long hold-off, counted here
            stall_left   = hold_request - 1;
            hold_request = 0;
            rsp_stall    = 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = idle_len() - 1;
            rsp_stall  = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // every accepted result beat is matched against the oldest owed sample
   always @(posedge clock) begin : check_outputs
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outputs_due.size() == 0) begin
            errors++;
            $error("result beat with nothing owed: sample_out %0d", rsp_data.sample_out);
         end else begin
            want = outputs_due.pop_front();
            if (rsp_data.sample_out !== want.sample_out) begin
               errors++;
               $error("sample_out: expected %0d, got %0d",
                      want.sample_out, rsp_data.sample_out);
            end
            if (rsp_data.saturated !== want.saturated) begin
               errors++;
               $error("saturated: expected %0b, got %0b",
                      want.saturated, rsp_data.saturated);
            end
            if (rsp_data.div_error !== want.div_error) begin
               errors++;
               $error("div_error: expected %0b, got %0b",
                      want.div_error, rsp_data.div_error);
            end
         end
      end
   end

   // main sequence
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      // reset values of the coefficients and history
      coef[REG_DEN_LEAD]   = COEF_ONE;
      coef[REG_DEN_FIRST]  = '0;
      coef[REG_DEN_SECOND] = '0;
      coef[REG_NUM_NOW]    = COEF_ONE;
      coef[REG_NUM_FIRST]  = '0;
      coef[REG_NUM_SECOND] = '0;
      x_hist1 = '0;
      x_hist2 = '0;
      y_hist1 = '0;
      y_hist2 = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_saturation();
      test_zero_lead();
      test_backpressure();
      test_random_traffic();
      wait_until_idle();
      if (errors == 0) begin
         $display("PASS normalized_iir_section_filter");
      end else begin
         $display("FAIL normalized_iir_section_filter");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("FAIL normalized_iir_section_filter");
      $finish;
   end

endmodule

// File: sim.f
hdl/nisf_pkg.sv
hdl/nisf_ctrl.sv
hdl/nisf_dp.sv
hdl/normalized_iir_section_filter.sv
bench/tb_normalized_iir_section_filter.sv
